### rtl/dtpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtpp_pkg;

    // Screen defaults
    localparam int SCREEN_WIDTH_DEF  = 160;
    localparam int SCREEN_HEIGHT_DEF = 44;

    // Arithmetic constants
    localparam int NEAR_LIMIT = 1638;           // 0.1 in Q.14
    localparam int NUM_W      = 40;             // divider dividend width
    localparam int DEN_W      = 28;             // divider divisor width
    localparam logic [NUM_W-1:0] OOZ_DIVIDEND = 40'h00_4000_0000;
    localparam logic [15:0] DEPTH_MAX   = 16'hFFFF;
    localparam logic [7:0]  GLYPH_SPACE = 8'd32;

    // Operation codes
    localparam logic OP_PLOT = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Configuration register indexes
    localparam logic [3:0] CFG_SIN_PITCH = 4'd0;
    localparam logic [3:0] CFG_COS_PITCH = 4'd1;
    localparam logic [3:0] CFG_SIN_YAW   = 4'd2;
    localparam logic [3:0] CFG_COS_YAW   = 4'd3;
    localparam logic [3:0] CFG_SIN_ROLL  = 4'd4;
    localparam logic [3:0] CFG_COS_ROLL  = 4'd5;
    localparam logic [3:0] CFG_CAM_DIST  = 4'd6;
    localparam logic [3:0] CFG_H_OFFSET  = 4'd7;

    typedef struct packed {
        logic              operation;
        logic signed [7:0] point_x;
        logic signed [7:0] point_y;
        logic signed [7:0] point_z;
        logic [7:0]        glyph;
        logic [12:0]       read_cell;
    } t_item;

    typedef struct packed {
        logic [7:0]  cell_glyph;
        logic        plotted;
        logic [12:0] target_cell;
    } t_result;

    typedef struct packed {
        logic              operation;
        logic              read_ok;
        logic signed [7:0] point_x;
        logic signed [7:0] point_y;
        logic signed [7:0] point_z;
        logic [7:0]        glyph;
        logic [12:0]       read_cell;
    } t_task;

    typedef struct packed {
        logic signed [15:0] sin_pitch;
        logic signed [15:0] cos_pitch;
        logic signed [15:0] sin_yaw;
        logic signed [15:0] cos_yaw;
        logic signed [15:0] sin_roll;
        logic signed [15:0] cos_roll;
        logic [9:0]         camera_distance;
        logic signed [7:0]  horizontal_offset;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RREQ, ST_RDAT, ST_DROP, ST_MUL, ST_CHK,
        ST_DSTART, ST_DWAIT, ST_CELLM, ST_CELLA, ST_RANGE, ST_PCMP
    } t_state;

    // Multiplier schedule: rotation coefficients, then point products
    typedef enum logic [4:0] {
        STP_SASB, STP_CASB, STP_CXI, STP_CXJ_A, STP_CXJ_B, STP_CXK_A,
        STP_CXK_B, STP_CYI, STP_CYJ_A, STP_CYJ_B, STP_CYK_A, STP_CYK_B,
        STP_CZJ, STP_CZK, STP_XI, STP_XJ, STP_XK, STP_YI, STP_YJ, STP_YK,
        STP_ZI, STP_ZJ, STP_ZK, STP_ZWAIT, STP_SCALE, STP_LAST
    } t_step;

    typedef enum logic [1:0] {DSEL_OOZ, DSEL_XP, DSEL_YP} t_dsel;

endpackage

`default_nettype wire

### rtl/dtpp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dtpp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 7040
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

### rtl/dtpp_div.sv
`timescale 1ns / 1ps
`default_nettype none

module dtpp_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [dtpp_pkg::NUM_W-1:0]     i_num,
    input  logic [dtpp_pkg::DEN_W-1:0]            i_den,
    output logic                                  o_done,
    output logic signed [dtpp_pkg::NUM_W-1:0]     o_quo
);
    localparam int NW    = dtpp_pkg::NUM_W;
    localparam int DW    = dtpp_pkg::DEN_W;
    localparam int STEPS = NW / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW:0]   r_rem;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_den;
    logic          r_neg;
    logic [DW:0]   w_rem;
    logic [NW-1:0] w_q;
    logic [NW-1:0] w_mag;

    assign w_mag = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);

    // Two restoring quotient bits per cycle
    always_comb begin
        w_rem = r_rem;
        w_q   = r_q;
        for (int b = 0; b < 2; b++) begin
            w_rem = {w_rem[DW-1:0], w_q[NW-1]};
            w_q   = {w_q[NW-2:0], 1'b0};
            if (w_rem >= {1'b0, r_den}) begin
                w_rem = w_rem - {1'b0, r_den};
                w_q[0] = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= w_mag;
            r_den <= i_den;
            r_neg <= i_num[NW-1];
        end else if (r_busy) begin
            r_rem <= w_rem;
            r_q   <= w_q;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule

`default_nettype wire

### rtl/dtpp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dtpp_front #(
    parameter int CELLS = 7040
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  dtpp_pkg::t_item   i_item,
    output logic              o_task_valid,
    input  logic              i_task_take,
    output dtpp_pkg::t_task   o_task
);
    dtpp_pkg::t_task r_slot [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            w_push;
    logic            w_take;
    dtpp_pkg::t_task w_task;

    assign full         = (r_cnt == 2'd2);
    assign o_task_valid = (r_cnt != 2'd0);
    assign w_push       = push && !full;
    assign w_take       = o_task_valid && i_task_take;
    assign o_task       = r_slot[r_rp];

    // Classify the request on entry
    always_comb begin
        w_task.operation = i_item.operation;
        w_task.read_ok   = (32'(i_item.read_cell) < 32'(CELLS));
        w_task.point_x   = i_item.point_x;
        w_task.point_y   = i_item.point_y;
        w_task.point_z   = i_item.point_z;
        w_task.glyph     = i_item.glyph;
        w_task.read_cell = i_item.read_cell;
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_take) begin
                r_rp <= !r_rp;
            end
            if (w_push && !w_take) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_push && w_take) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Hold queued requests
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= w_task;
        end
    end
endmodule

`default_nettype wire

### rtl/dtpp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module dtpp_back #(
    parameter int SCREEN_WIDTH  = dtpp_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = dtpp_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dtpp_pkg::t_cfg     i_cfg,
    input  logic               i_cfg_we,
    input  logic               i_task_valid,
    output logic               o_task_take,
    input  dtpp_pkg::t_task    i_task,
    input  logic               pop,
    output logic               empty,
    output dtpp_pkg::t_result  o_result
);
    localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int NW    = dtpp_pkg::NUM_W;
    localparam logic signed [10:0] HALF_W  = 11'(SCREEN_WIDTH / 2);
    localparam logic signed [10:0] HALF_H  = 11'(SCREEN_HEIGHT / 2);
    localparam logic signed [20:0] WIDTH_S = 21'(SCREEN_WIDTH);

    dtpp_pkg::t_state  r_state, n_state;
    dtpp_pkg::t_task   r_task;
    dtpp_pkg::t_step   r_step, r_cstep;
    dtpp_pkg::t_dsel   r_dsel;
    dtpp_pkg::t_result r_out, w_res;
    logic              r_out_full;
    logic              w_res_load;
    logic              r_cv;
    logic              r_coef_ok;
    logic [AW-1:0]     r_clr;

    logic signed [19:0] r_sasb, r_casb, r_cxi, r_cxj, r_cxk;
    logic signed [19:0] r_cyi, r_cyj, r_cyk, r_czj, r_czk;
    logic signed [27:0] r_x, r_y, r_z;
    logic signed [NW-1:0] r_nx, r_ny, r_cell;
    logic signed [27:0] r_xp, r_yp;
    logic [15:0]        r_ooz;
    logic signed [48:0] r_prod;
    logic signed [20:0] w_mul_a;
    logic signed [27:0] w_mul_b;
    logic signed [19:0] w_p14;
    logic signed [27:0] w_p0;
    logic signed [10:0] w_hoff;
    logic signed [27:0] w_cam;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [23:0]   w_wdata, w_rdata;
    logic          w_win;
    logic          w_off;

    logic                 w_div_start, w_div_done;
    logic signed [NW-1:0] w_div_num, w_div_quo;

    dtpp_ram #(.WIDTH(24), .DEPTH(CELLS)) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    dtpp_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_div_num),
        .i_den  (r_z),
        .o_done (w_div_done),
        .o_quo  (w_div_quo)
    );

    assign w_p14  = 20'(r_prod >>> 14);
    assign w_p0   = 28'(r_prod);
    assign w_hoff = HALF_W + 11'(i_cfg.horizontal_offset);
    assign w_cam  = $signed({4'b0, i_cfg.camera_distance, 14'b0});
    assign w_win  = (r_ooz > w_rdata[23:8]);
    assign w_off  = r_cell[NW-1] || (r_cell >= $signed(NW'(CELLS)));
    assign empty    = !r_out_full;
    assign o_result = r_out;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dtpp_pkg::ST_CLEAR: begin
                if (r_clr == AW'(CELLS - 1)) n_state = dtpp_pkg::ST_IDLE;
            end
            dtpp_pkg::ST_IDLE: begin
                if (i_task_valid && !r_out_full) begin
                    if (i_task.operation == dtpp_pkg::OP_READ) begin
                        n_state = i_task.read_ok ? dtpp_pkg::ST_RREQ : dtpp_pkg::ST_DROP;
                    end else begin
                        n_state = dtpp_pkg::ST_MUL;
                    end
                end
            end
            dtpp_pkg::ST_RREQ:  n_state = dtpp_pkg::ST_RDAT;
            dtpp_pkg::ST_RDAT:  n_state = dtpp_pkg::ST_IDLE;
            dtpp_pkg::ST_DROP:  n_state = dtpp_pkg::ST_IDLE;
            dtpp_pkg::ST_MUL: begin
                if (r_step == dtpp_pkg::STP_LAST) n_state = dtpp_pkg::ST_CHK;
            end
            dtpp_pkg::ST_CHK: begin
                n_state = (r_z <= $signed(28'(dtpp_pkg::NEAR_LIMIT))) ?
                          dtpp_pkg::ST_DROP : dtpp_pkg::ST_DSTART;
            end
            dtpp_pkg::ST_DSTART: n_state = dtpp_pkg::ST_DWAIT;
            dtpp_pkg::ST_DWAIT: begin
                if (w_div_done) begin
                    n_state = (r_dsel == dtpp_pkg::DSEL_YP) ?
                              dtpp_pkg::ST_CELLM : dtpp_pkg::ST_DSTART;
                end
            end
            dtpp_pkg::ST_CELLM: n_state = dtpp_pkg::ST_CELLA;
            dtpp_pkg::ST_CELLA: n_state = dtpp_pkg::ST_RANGE;
            dtpp_pkg::ST_RANGE: n_state = w_off ? dtpp_pkg::ST_DROP : dtpp_pkg::ST_PCMP;
            dtpp_pkg::ST_PCMP:  n_state = dtpp_pkg::ST_IDLE;
            default:            n_state = dtpp_pkg::ST_IDLE;
        endcase
    end

    // State outputs: store access, results, divider start
    always_comb begin
        o_task_take = 1'b0;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_wdata     = {16'd0, dtpp_pkg::GLYPH_SPACE};
        w_raddr     = '0;
        w_res_load  = 1'b0;
        w_res       = '0;
        w_div_start = 1'b0;
        case (r_state)
            dtpp_pkg::ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
            end
            dtpp_pkg::ST_IDLE: begin
                o_task_take = i_task_valid && !r_out_full;
            end
            dtpp_pkg::ST_RREQ: begin
                w_raddr = AW'(r_task.read_cell);
            end
            dtpp_pkg::ST_RDAT: begin
                w_we             = 1'b1;
                w_waddr          = AW'(r_task.read_cell);
                w_res_load       = 1'b1;
                w_res.cell_glyph = w_rdata[7:0];
            end
            dtpp_pkg::ST_DROP: begin
                w_res_load = 1'b1;
            end
            dtpp_pkg::ST_DSTART: begin
                w_div_start = 1'b1;
            end
            dtpp_pkg::ST_RANGE: begin
                w_raddr = r_cell[AW-1:0];
            end
            dtpp_pkg::ST_PCMP: begin
                w_we              = w_win;
                w_waddr           = r_cell[AW-1:0];
                w_wdata           = {r_ooz, r_task.glyph};
                w_res_load        = 1'b1;
                w_res.plotted     = w_win;
                w_res.target_cell = r_cell[12:0];
            end
            default: begin
            end
        endcase
    end

    // Divider operand select
    always_comb begin
        case (r_dsel)
            dtpp_pkg::DSEL_OOZ: w_div_num = $signed(dtpp_pkg::OOZ_DIVIDEND);
            dtpp_pkg::DSEL_XP:  w_div_num = r_nx;
            dtpp_pkg::DSEL_YP:  w_div_num = r_ny;
            default:            w_div_num = r_ny;
        endcase
    end

    // Multiplier operand schedule
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        if (r_state == dtpp_pkg::ST_CELLM) begin
            w_mul_a = WIDTH_S;
            w_mul_b = r_yp;
        end else begin
            case (r_step)
                dtpp_pkg::STP_SASB:  begin w_mul_a = 21'(i_cfg.sin_pitch); w_mul_b = 28'(i_cfg.sin_yaw);  end
                dtpp_pkg::STP_CASB:  begin w_mul_a = 21'(i_cfg.cos_pitch); w_mul_b = 28'(i_cfg.sin_yaw);  end
                dtpp_pkg::STP_CXI:   begin w_mul_a = 21'(i_cfg.cos_yaw);   w_mul_b = 28'(i_cfg.cos_roll); end
                dtpp_pkg::STP_CXJ_A: begin w_mul_a = 21'(r_sasb);          w_mul_b = 28'(i_cfg.cos_roll); end
                dtpp_pkg::STP_CXJ_B: begin w_mul_a = 21'(i_cfg.cos_pitch); w_mul_b = 28'(i_cfg.sin_roll); end
                dtpp_pkg::STP_CXK_A: begin w_mul_a = 21'(i_cfg.sin_pitch); w_mul_b = 28'(i_cfg.sin_roll); end
                dtpp_pkg::STP_CXK_B: begin w_mul_a = 21'(r_casb);          w_mul_b = 28'(i_cfg.cos_roll); end
                dtpp_pkg::STP_CYI:   begin w_mul_a = 21'(i_cfg.cos_yaw);   w_mul_b = 28'(i_cfg.sin_roll); end
                dtpp_pkg::STP_CYJ_A: begin w_mul_a = 21'(i_cfg.cos_pitch); w_mul_b = 28'(i_cfg.cos_roll); end
                dtpp_pkg::STP_CYJ_B: begin w_mul_a = 21'(r_sasb);          w_mul_b = 28'(i_cfg.sin_roll); end
                dtpp_pkg::STP_CYK_A: begin w_mul_a = 21'(i_cfg.sin_pitch); w_mul_b = 28'(i_cfg.cos_roll); end
                dtpp_pkg::STP_CYK_B: begin w_mul_a = 21'(r_casb);          w_mul_b = 28'(i_cfg.sin_roll); end
                dtpp_pkg::STP_CZJ:   begin w_mul_a = 21'(i_cfg.sin_pitch); w_mul_b = 28'(i_cfg.cos_yaw);  end
                dtpp_pkg::STP_CZK:   begin w_mul_a = 21'(i_cfg.cos_pitch); w_mul_b = 28'(i_cfg.cos_yaw);  end
                dtpp_pkg::STP_XI:    begin w_mul_a = 21'(r_cxi); w_mul_b = 28'(r_task.point_x); end
                dtpp_pkg::STP_XJ:    begin w_mul_a = 21'(r_cxj); w_mul_b = 28'(r_task.point_y); end
                dtpp_pkg::STP_XK:    begin w_mul_a = 21'(r_cxk); w_mul_b = 28'(r_task.point_z); end
                dtpp_pkg::STP_YI:    begin w_mul_a = 21'(r_cyi); w_mul_b = 28'(r_task.point_x); end
                dtpp_pkg::STP_YJ:    begin w_mul_a = 21'(r_cyj); w_mul_b = 28'(r_task.point_y); end
                dtpp_pkg::STP_YK:    begin w_mul_a = 21'(r_cyk); w_mul_b = 28'(r_task.point_z); end
                dtpp_pkg::STP_ZI:    begin w_mul_a = 21'(i_cfg.sin_yaw); w_mul_b = 28'(r_task.point_x); end
                dtpp_pkg::STP_ZJ:    begin w_mul_a = 21'(r_czj); w_mul_b = 28'(r_task.point_y); end
                dtpp_pkg::STP_ZK:    begin w_mul_a = 21'(r_czk); w_mul_b = 28'(r_task.point_z); end
                dtpp_pkg::STP_SCALE: begin w_mul_a = 21'(w_hoff); w_mul_b = r_z; end
                dtpp_pkg::STP_LAST:  begin w_mul_a = 21'(HALF_H); w_mul_b = r_z; end
                default: begin
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= dtpp_pkg::ST_CLEAR;
            r_clr      <= '0;
            r_coef_ok  <= 1'b0;
            r_out_full <= 1'b0;
            r_cv       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cv    <= (r_state == dtpp_pkg::ST_MUL);
            if (r_state == dtpp_pkg::ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            // drop cached coefficients on any register write
            if (i_cfg_we) begin
                r_coef_ok <= 1'b0;
            end else if (r_state == dtpp_pkg::ST_MUL && r_step == dtpp_pkg::STP_LAST) begin
                r_coef_ok <= 1'b1;
            end
            if (w_res_load) begin
                r_out_full <= 1'b1;
            end else if (pop && r_out_full) begin
                r_out_full <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod  <= w_mul_a * w_mul_b;
        r_cstep <= r_step;
        if (w_res_load) begin
            r_out <= w_res;
        end
        if (o_task_take) begin
            r_task <= i_task;
            r_step <= r_coef_ok ? dtpp_pkg::STP_XI : dtpp_pkg::STP_SASB;
        end else if (r_state == dtpp_pkg::ST_MUL) begin
            r_step <= dtpp_pkg::t_step'(r_step + 5'd1);
        end

        // capture the product issued in the previous cycle
        if (r_cv) begin
            case (r_cstep)
                dtpp_pkg::STP_SASB:  r_sasb <= w_p14;
                dtpp_pkg::STP_CASB:  r_casb <= w_p14;
                dtpp_pkg::STP_CXI:   r_cxi  <= w_p14;
                dtpp_pkg::STP_CXJ_A: r_cxj  <= w_p14;
                dtpp_pkg::STP_CXJ_B: r_cxj  <= r_cxj + w_p14;
                dtpp_pkg::STP_CXK_A: r_cxk  <= w_p14;
                dtpp_pkg::STP_CXK_B: r_cxk  <= r_cxk - w_p14;
                dtpp_pkg::STP_CYI:   r_cyi  <= -w_p14;
                dtpp_pkg::STP_CYJ_A: r_cyj  <= w_p14;
                dtpp_pkg::STP_CYJ_B: r_cyj  <= r_cyj - w_p14;
                dtpp_pkg::STP_CYK_A: r_cyk  <= w_p14;
                dtpp_pkg::STP_CYK_B: r_cyk  <= r_cyk + w_p14;
                dtpp_pkg::STP_CZJ:   r_czj  <= -w_p14;
                dtpp_pkg::STP_CZK:   r_czk  <= w_p14;
                dtpp_pkg::STP_XI:    r_x    <= w_p0;
                dtpp_pkg::STP_XJ:    r_x    <= r_x + w_p0;
                dtpp_pkg::STP_XK:    r_x    <= r_x + w_p0;
                dtpp_pkg::STP_YI:    r_y    <= w_p0;
                dtpp_pkg::STP_YJ:    r_y    <= r_y + w_p0;
                dtpp_pkg::STP_YK:    r_y    <= r_y + w_p0;
                dtpp_pkg::STP_ZI:    r_z    <= w_p0 + w_cam;
                dtpp_pkg::STP_ZJ:    r_z    <= r_z + w_p0;
                dtpp_pkg::STP_ZK:    r_z    <= r_z + w_p0;
                dtpp_pkg::STP_SCALE: r_nx   <= NW'(r_prod) + (NW'(r_x) <<< 6)
                                               + (NW'(r_x) <<< 4);
                default: begin
                end
            endcase
        end

        // vertical numerator from the last product; start division sequence
        if (r_state == dtpp_pkg::ST_CHK) begin
            r_ny   <= NW'(r_prod) + (NW'(r_y) <<< 5) + (NW'(r_y) <<< 3);
            r_dsel <= dtpp_pkg::DSEL_OOZ;
        end

        // collect quotients
        if (r_state == dtpp_pkg::ST_DWAIT && w_div_done) begin
            case (r_dsel)
                dtpp_pkg::DSEL_OOZ: begin
                    r_ooz  <= (w_div_quo > $signed(NW'(dtpp_pkg::DEPTH_MAX))) ?
                              dtpp_pkg::DEPTH_MAX : w_div_quo[15:0];
                    r_dsel <= dtpp_pkg::DSEL_XP;
                end
                dtpp_pkg::DSEL_XP: begin
                    r_xp   <= 28'(w_div_quo);
                    r_dsel <= dtpp_pkg::DSEL_YP;
                end
                default: r_yp <= 28'(w_div_quo);
            endcase
        end

        if (r_state == dtpp_pkg::ST_CELLA) begin
            r_cell <= NW'(r_prod) + NW'(r_xp);
        end
    end
endmodule

`default_nettype wire

### rtl/depth_tested_point_projector.sv
`timescale 1ns / 1ps
`default_nettype none

// Depth-tested point projector with an on-chip character frame and depth store.
// Input queue: drive i_item and raise push while full is low. operation 0
// plots a point, operation 1 reads one cell and clears it to a space.
// Result queue: while empty is low o_result holds the oldest result; raise
// pop to take it. Every request gives exactly one result, in order.
// Configuration: write register i_cfg_index with i_cfg_data when i_cfg_valid
// is high; o_cfg_ready is always high. Write only while the block is idle.
// One shared 21x28 multiplier works through the point products, and first
// rebuilds the rotation coefficients after reset or a register write; the
// three divisions run one after another in a two-bit-per-cycle divider.
// One request is worked on at a time; the next one is taken the cycle after
// the previous result is popped. A stalled receiver holds the back end; push
// is refused once the two-entry input queue has filled.
// Reset: a clearing pass over all SCREEN_WIDTH*SCREEN_HEIGHT cells (7040 by
// default) fills the store with depth 0 and spaces before the first
// request is started; up to two requests are queued meanwhile.
module depth_tested_point_projector #(
    parameter int SCREEN_WIDTH  = dtpp_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = dtpp_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  dtpp_pkg::t_item   i_item,
    output logic              empty,
    input  logic              pop,
    output dtpp_pkg::t_result o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [3:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);
    dtpp_pkg::t_cfg  r_cfg;
    dtpp_pkg::t_task w_task;
    logic            w_task_valid;
    logic            w_task_take;
    logic            w_cfg_we;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sin_pitch         <= 16'sd0;
            r_cfg.cos_pitch         <= 16'sd16384;
            r_cfg.sin_yaw           <= 16'sd0;
            r_cfg.cos_yaw           <= 16'sd16384;
            r_cfg.sin_roll          <= 16'sd0;
            r_cfg.cos_roll          <= 16'sd16384;
            r_cfg.camera_distance   <= 10'd100;
            r_cfg.horizontal_offset <= 8'sd0;
        end else if (w_cfg_we) begin
            case (i_cfg_index)
                dtpp_pkg::CFG_SIN_PITCH: r_cfg.sin_pitch         <= i_cfg_data;
                dtpp_pkg::CFG_COS_PITCH: r_cfg.cos_pitch         <= i_cfg_data;
                dtpp_pkg::CFG_SIN_YAW:   r_cfg.sin_yaw           <= i_cfg_data;
                dtpp_pkg::CFG_COS_YAW:   r_cfg.cos_yaw           <= i_cfg_data;
                dtpp_pkg::CFG_SIN_ROLL:  r_cfg.sin_roll          <= i_cfg_data;
                dtpp_pkg::CFG_COS_ROLL:  r_cfg.cos_roll          <= i_cfg_data;
                dtpp_pkg::CFG_CAM_DIST:  r_cfg.camera_distance   <= i_cfg_data[9:0];
                dtpp_pkg::CFG_H_OFFSET:  r_cfg.horizontal_offset <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    dtpp_front #(.CELLS(SCREEN_WIDTH * SCREEN_HEIGHT)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_task_valid(w_task_valid),
        .i_task_take (w_task_take),
        .o_task      (w_task)
    );

    dtpp_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cfg_we    (w_cfg_we),
        .i_task_valid(w_task_valid),
        .o_task_take (w_task_take),
        .i_task      (w_task),
        .pop         (pop),
        .empty       (empty),
        .o_result    (o_result)
    );
endmodule

`default_nettype wire
